### rtl/ccpe_pkg.sv
// Shared constants and types for the cubic curve point evaluator.
// No dependencies; every rtl file imports this package.
`timescale 1ns / 1ps

package ccpe_pkg;

  // Default parameter values of the top level
  localparam int PARAM_FRAC_BITS_DEF = 16;
  localparam int COORD_BITS_DEF      = 16;

  // Extra fraction bits carried through the Horner steps
  localparam int GUARD_BITS = 7;

  // Headroom over the coordinate width: coefficients and Horner accumulator
  localparam int COEF_HEAD = 8;
  localparam int ACC_HEAD  = 10;

  localparam int NODE_COUNT = 4;
  localparam int AXIS_COUNT = 3;
  localparam int COEF_COUNT = 3;   // c2, c1, c0 carried after c3 is consumed
  localparam int NODE_W     = 2;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_ZERO  = 3'd0,
    REG_POINT_ONE   = 3'd1,
    REG_POINT_TWO   = 3'd2,
    REG_POINT_THREE = 3'd3
  } cfg_reg_e;

  // Reset nodes in Q8.8, field index 0 = z, 1 = y, 2 = x
  localparam logic signed [23:0] NODE_RESET [NODE_COUNT][AXIS_COUNT] = '{
    '{24'sd0, 24'sd0,    24'sd1792},
    '{24'sd0, 24'sd256,  24'sd1280},
    '{24'sd0, 24'sd0,    24'sd3840},
    '{24'sd0, 24'sd1024, 24'sd0}
  };

endpackage

### rtl/ccpe_coef_stage.sv
// Pipeline stage forming the doubled polynomial coefficients per axis.
// Depends on ccpe_pkg.
`timescale 1ns / 1ps

module ccpe_coef_stage #(
  parameter int PARAM_FRAC_BITS = ccpe_pkg::PARAM_FRAC_BITS_DEF,
  parameter int COORD_BITS      = ccpe_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   vld_i,
  output logic                                   rdy_o,
  input  logic [PARAM_FRAC_BITS:0]               u_i,
  input  logic [3*COORD_BITS-1:0]                node_i [ccpe_pkg::NODE_COUNT],
  output logic                                   vld_o,
  input  logic                                   rdy_i,
  output logic [PARAM_FRAC_BITS:0]               u_o,
  output logic signed [COORD_BITS+ccpe_pkg::GUARD_BITS+ccpe_pkg::ACC_HEAD-1:0]
                                                 acc_o [ccpe_pkg::AXIS_COUNT],
  output logic signed [COORD_BITS+ccpe_pkg::COEF_HEAD-1:0]
                                                 coef_o [ccpe_pkg::AXIS_COUNT]
                                                        [ccpe_pkg::COEF_COUNT]
);
  import ccpe_pkg::*;

  localparam int CW = COORD_BITS + COEF_HEAD;
  localparam int AW = COORD_BITS + GUARD_BITS + ACC_HEAD;

  localparam logic signed [CW-1:0] K2  = CW'(2);
  localparam logic signed [CW-1:0] K9  = CW'(9);
  localparam logic signed [CW-1:0] K11 = CW'(11);
  localparam logic signed [CW-1:0] K18 = CW'(18);
  localparam logic signed [CW-1:0] K27 = CW'(27);
  localparam logic signed [CW-1:0] K36 = CW'(36);
  localparam logic signed [CW-1:0] K45 = CW'(45);

  logic                    vld_q;
  logic [PARAM_FRAC_BITS:0] u_q;
  logic signed [AW-1:0]    acc_d  [AXIS_COUNT];
  logic signed [AW-1:0]    acc_q  [AXIS_COUNT];
  logic signed [CW-1:0]    coef_d [AXIS_COUNT][COEF_COUNT];
  logic signed [CW-1:0]    coef_q [AXIS_COUNT][COEF_COUNT];

  assign rdy_o = !vld_q || rdy_i;

  always_comb begin
    logic signed [CW-1:0] p0, p1, p2, p3, c3;
    p0 = '0;
    p1 = '0;
    p2 = '0;
    p3 = '0;
    c3 = '0;
    for (int k = 0; k < AXIS_COUNT; k++) begin
      p0 = CW'($signed(node_i[0][k*COORD_BITS +: COORD_BITS]));
      p1 = CW'($signed(node_i[1][k*COORD_BITS +: COORD_BITS]));
      p2 = CW'($signed(node_i[2][k*COORD_BITS +: COORD_BITS]));
      p3 = CW'($signed(node_i[3][k*COORD_BITS +: COORD_BITS]));
      c3 = K9 * (p3 - p0) + K27 * (p1 - p2);
      coef_d[k][0] = K18 * p0 - K45 * p1 + K36 * p2 - K9 * p3;
      coef_d[k][1] = K18 * p1 - K11 * p0 - K9 * p2 + K2 * p3;
      coef_d[k][2] = K2 * p0;
      acc_d[k]     = AW'(c3) <<< GUARD_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i && rdy_o) begin
      u_q    <= u_i;
      acc_q  <= acc_d;
      coef_q <= coef_d;
    end
  end

  assign vld_o  = vld_q;
  assign u_o    = u_q;
  assign acc_o  = acc_q;
  assign coef_o = coef_q;

endmodule

### rtl/ccpe_horner_stage.sv
// One Horner step per axis: multiply by u, round half up, add next coefficient.
// Depends on ccpe_pkg.
`timescale 1ns / 1ps

module ccpe_horner_stage #(
  parameter int PARAM_FRAC_BITS = ccpe_pkg::PARAM_FRAC_BITS_DEF,
  parameter int COORD_BITS      = ccpe_pkg::COORD_BITS_DEF,
  parameter int STEP            = 0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   vld_i,
  output logic                                   rdy_o,
  input  logic [PARAM_FRAC_BITS:0]               u_i,
  input  logic signed [COORD_BITS+ccpe_pkg::GUARD_BITS+ccpe_pkg::ACC_HEAD-1:0]
                                                 acc_i [ccpe_pkg::AXIS_COUNT],
  input  logic signed [COORD_BITS+ccpe_pkg::COEF_HEAD-1:0]
                                                 coef_i [ccpe_pkg::AXIS_COUNT]
                                                        [ccpe_pkg::COEF_COUNT],
  output logic                                   vld_o,
  input  logic                                   rdy_i,
  output logic [PARAM_FRAC_BITS:0]               u_o,
  output logic signed [COORD_BITS+ccpe_pkg::GUARD_BITS+ccpe_pkg::ACC_HEAD-1:0]
                                                 acc_o [ccpe_pkg::AXIS_COUNT],
  output logic signed [COORD_BITS+ccpe_pkg::COEF_HEAD-1:0]
                                                 coef_o [ccpe_pkg::AXIS_COUNT]
                                                        [ccpe_pkg::COEF_COUNT]
);
  import ccpe_pkg::*;

  localparam int CW = COORD_BITS + COEF_HEAD;
  localparam int AW = COORD_BITS + GUARD_BITS + ACC_HEAD;
  localparam int PW = AW + PARAM_FRAC_BITS + 2;
  localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (PARAM_FRAC_BITS - 1);

  logic                     vld_q;
  logic [PARAM_FRAC_BITS:0] u_q;
  logic signed [AW-1:0]     acc_d  [AXIS_COUNT];
  logic signed [AW-1:0]     acc_q  [AXIS_COUNT];
  logic signed [CW-1:0]     coef_q [AXIS_COUNT][COEF_COUNT];

  assign rdy_o = !vld_q || rdy_i;

  always_comb begin
    logic signed [PW-1:0] prod, shifted;
    logic signed [PARAM_FRAC_BITS+1:0] u_s;
    u_s     = $signed({1'b0, u_i});
    prod    = '0;
    shifted = '0;
    for (int k = 0; k < AXIS_COUNT; k++) begin
      prod     = PW'(acc_i[k]) * PW'(u_s);
      // floor((v + half) / 2^F) gives round half up
      shifted  = (prod + RND_HALF) >>> PARAM_FRAC_BITS;
      acc_d[k] = shifted[AW-1:0] + (AW'(coef_i[k][STEP]) <<< GUARD_BITS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i && rdy_o) begin
      u_q    <= u_i;
      acc_q  <= acc_d;
      coef_q <= coef_i;
    end
  end

  assign vld_o  = vld_q;
  assign u_o    = u_q;
  assign acc_o  = acc_q;
  assign coef_o = coef_q;

endmodule

### rtl/ccpe_round_sat.sv
// Output register: drop guard bits and the coefficient doubling with round half up, then saturate.
// Depends on ccpe_pkg.
`timescale 1ns / 1ps

module ccpe_round_sat #(
  parameter int COORD_BITS = ccpe_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   vld_i,
  output logic                                   rdy_o,
  input  logic signed [COORD_BITS+ccpe_pkg::GUARD_BITS+ccpe_pkg::ACC_HEAD-1:0]
                                                 acc_i [ccpe_pkg::AXIS_COUNT],
  output logic                                   vld_o,
  input  logic                                   rdy_i,
  output logic signed [COORD_BITS+1:0]           coord_o [ccpe_pkg::AXIS_COUNT]
);
  import ccpe_pkg::*;

  localparam int AW = COORD_BITS + GUARD_BITS + ACC_HEAD;
  localparam logic signed [AW-1:0] RND_HALF = AW'(1) <<< GUARD_BITS;
  localparam logic signed [AW-1:0] SAT_HI   = (AW'(1) <<< (COORD_BITS + 1)) - AW'(1);
  localparam logic signed [AW-1:0] SAT_LO   = -(AW'(1) <<< (COORD_BITS + 1));

  logic                          vld_q;
  logic signed [COORD_BITS+1:0]  coord_d [AXIS_COUNT];
  logic signed [COORD_BITS+1:0]  coord_q [AXIS_COUNT];

  assign rdy_o = !vld_q || rdy_i;

  always_comb begin
    logic signed [AW-1:0] r;
    r = '0;
    for (int k = 0; k < AXIS_COUNT; k++) begin
      r = (acc_i[k] + RND_HALF) >>> (GUARD_BITS + 1);
      if (r > SAT_HI) begin
        r = SAT_HI;
      end else if (r < SAT_LO) begin
        r = SAT_LO;
      end
      coord_d[k] = r[COORD_BITS+1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i && rdy_o) begin
      coord_q <= coord_d;
    end
  end

  assign vld_o   = vld_q;
  assign coord_o = coord_q;

endmodule

### rtl/cubic_curve_point_evaluator_top.sv
// Top level of the cubic curve point evaluator: node registers and pipeline.
// Depends on ccpe_pkg, ccpe_coef_stage, ccpe_horner_stage, ccpe_round_sat.
`timescale 1ns / 1ps

// Channel    Direction  Contents
// s_axis     in         tdata: curve_param (u, unsigned Q1.F, clamped to 1.0)
// m_axis     out        tdata: coord_x, coord_y, coord_z (signed, saturated)
// cfg        in         write enable, register index 0..3, node value x|y|z
//
// One request per cycle is taken while the output is not stalled; each
// result passes in order through the input register, coefficient stage, three Horner
// stages (one multiply each) and the round/saturate output register.
// Every stage holds its own valid bit and advances when the next one is free,
// so a stalled output only stops the stages behind it once they are full.
// Reset clears all valid bits and loads the default nodes.

module cubic_curve_point_evaluator_top #(
  parameter int PARAM_FRAC_BITS = ccpe_pkg::PARAM_FRAC_BITS_DEF,
  parameter int COORD_BITS      = ccpe_pkg::COORD_BITS_DEF,
  localparam int IN_W  = ((PARAM_FRAC_BITS + 1 + 7) / 8) * 8,
  localparam int OUT_W = ((3 * (COORD_BITS + 2) + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // [PARAM_FRAC_BITS:0] curve_param
  input  logic [IN_W-1:0]                   s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [C+1:0] coord_x, [2C+3:C+2] coord_y, [3C+5:2C+4] coord_z, C = COORD_BITS
  output logic [OUT_W-1:0]                  m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [ccpe_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [3*COORD_BITS-1:0]           cfg_data_i
);
  import ccpe_pkg::*;

  localparam int F  = PARAM_FRAC_BITS;
  localparam int CW = COORD_BITS + COEF_HEAD;
  localparam int AW = COORD_BITS + GUARD_BITS + ACC_HEAD;
  localparam int OW = COORD_BITS + 2;
  localparam int NSTAGE = 3;
  localparam logic [F:0] U_ONE = {1'b1, {F{1'b0}}};

  // Node registers
  logic [3*COORD_BITS-1:0] node_q [NODE_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NODE_COUNT; n++) begin
        for (int k = 0; k < AXIS_COUNT; k++) begin
          node_q[n][k*COORD_BITS +: COORD_BITS] <= NODE_RESET[n][k][COORD_BITS-1:0];
        end
      end
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_POINT_ZERO, REG_POINT_ONE, REG_POINT_TWO, REG_POINT_THREE: begin
          node_q[cfg_addr_i[NODE_W-1:0]] <= cfg_data_i;
        end
        default: begin
          // unknown index: ignore the write
        end
      endcase
    end
  end

  // Input register with parameter clamp
  logic         in_vld_q;
  logic [F:0]   u_q;
  logic [F:0]   u_d;
  logic         coef_rdy;

  assign u_d           = (s_axis_tdata[F:0] > U_ONE) ? U_ONE : s_axis_tdata[F:0];
  assign s_axis_tready = !in_vld_q || coef_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      u_q <= u_d;
    end
  end

  // Pipeline links: index 0 leaves the coefficient stage, index k+1 Horner step k
  logic                 vld_s  [NSTAGE+1];
  logic                 rdy_s  [NSTAGE+1];
  logic [F:0]           u_s    [NSTAGE+1];
  logic signed [AW-1:0] acc_s  [NSTAGE+1][AXIS_COUNT];
  logic signed [CW-1:0] coef_s [NSTAGE+1][AXIS_COUNT][COEF_COUNT];

  ccpe_coef_stage #(
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS),
    .COORD_BITS      (COORD_BITS)
  ) u_coef (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (in_vld_q),
    .rdy_o  (coef_rdy),
    .u_i    (u_q),
    .node_i (node_q),
    .vld_o  (vld_s[0]),
    .rdy_i  (rdy_s[0]),
    .u_o    (u_s[0]),
    .acc_o  (acc_s[0]),
    .coef_o (coef_s[0])
  );

  for (genvar g = 0; g < NSTAGE; g++) begin : g_horner
    ccpe_horner_stage #(
      .PARAM_FRAC_BITS (PARAM_FRAC_BITS),
      .COORD_BITS      (COORD_BITS),
      .STEP            (g)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld_s[g]),
      .rdy_o  (rdy_s[g]),
      .u_i    (u_s[g]),
      .acc_i  (acc_s[g]),
      .coef_i (coef_s[g]),
      .vld_o  (vld_s[g+1]),
      .rdy_i  (rdy_s[g+1]),
      .u_o    (u_s[g+1]),
      .acc_o  (acc_s[g+1]),
      .coef_o (coef_s[g+1])
    );
  end

  logic signed [OW-1:0] coord [AXIS_COUNT];

  ccpe_round_sat #(
    .COORD_BITS (COORD_BITS)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (vld_s[NSTAGE]),
    .rdy_o   (rdy_s[NSTAGE]),
    .acc_i   (acc_s[NSTAGE]),
    .vld_o   (m_axis_tvalid),
    .rdy_i   (m_axis_tready),
    .coord_o (coord)
  );

  // Field index 2 is x, 1 is y, 0 is z; x goes out in the lowest bits
  assign m_axis_tdata = {{(OUT_W - 3 * OW){1'b0}}, coord[0], coord[1], coord[2]};

  // Input can only be held off when the whole chain is full and the output stalls
  a_stall_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while output free");

  // An accepted request must occupy the input register next cycle
  a_accept_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> in_vld_q)
    else $error("accepted request lost at input register");

  // An empty pipeline must accept
  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_vld_q && !vld_s[0] && !vld_s[1] && !vld_s[2] && !vld_s[3] && !m_axis_tvalid)
      |-> s_axis_tready)
    else $error("empty pipeline refuses input");

endmodule
